// ===== sv/kmer_minhash_signature_defines.svh =====
// assertion helpers, clocked on clk, disabled during reset
`ifndef KMER_MINHASH_SIGNATURE_DEFINES_SVH
`define KMER_MINHASH_SIGNATURE_DEFINES_SVH

`define KMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kms check failed");

`define KMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kms check failed");

`endif

// ===== sv/kms_pkg.sv =====
package kms_pkg;

	localparam int MAX_HASHES = 64;
	localparam int MAX_KMER   = 32;
	localparam int HIDX_W     = $clog2(MAX_HASHES);
	localparam int KLEN_W     = 6;
	localparam int HCNT_W     = 7;
	localparam int CFG_W      = 7;
	localparam int WIN_W      = MAX_KMER * 8;
	localparam int NBLK       = (MAX_KMER + 3) / 4;
	localparam int BLK_W      = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int BCNT_W     = $clog2(NBLK + 3);

	localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2 = 32'h1b873593;
	localparam logic [31:0] RND_C  = 32'he6546b64;
	localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
	localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

	localparam logic [1:0] KIND_SEED   = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic CFG_KMER_LEN   = 1'b0;
	localparam logic CFG_HASH_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  seed_index;
		logic [31:0] seed_value;
		logic [7:0]  symbol;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  hash_index;
		logic [31:0] min_hash;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic             vld;
		logic [BLK_W-1:0] idx;
		logic [31:0]      word;
	} mix_req_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
		rotl32 = (x << r) | (x >> (32 - r));
	endfunction

endpackage

// ===== sv/kms_ram.sv =====
module kms_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/kms_block_mix.sv =====
module kms_block_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  kms_pkg::mix_req_t req,
	output kms_pkg::mix_req_t rsp
);
	import kms_pkg::*;

	logic             vld_s1, vld_s2;
	logic [BLK_W-1:0] idx_s1, idx_s2;
	logic [31:0]      p_s1, m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= req.idx;
		p_s1   <= req.word * MIX_C1;
		idx_s2 <= idx_s1;
		m_s2   <= rotl32(p_s1, 15) * MIX_C2;
	end

	assign rsp.vld  = vld_s2;
	assign rsp.idx  = idx_s2;
	assign rsp.word = m_s2;

endmodule

// ===== sv/kmer_minhash_signature.sv =====
// Seed loads are taken without leaving idle. A sequence byte that completes
// a k-mer goes through block mixing, then once per seed through the shared
// round and finalize datapath; other bytes are taken without leaving idle.
// End of sequence emits one word per hash (signature RAM read each word).
// Reset is asynchronous active low; signatures read as all ones via valid bits.
module kmer_minhash_signature (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  kms_pkg::in_item_t           item,
	output logic                        word_valid,
	input  logic                        word_ready,
	output kms_pkg::out_item_t          word,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [kms_pkg::CFG_W-1:0]   cfg_data
);
	import kms_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MIX  = 9'b000000010,
		S_SRD  = 9'b000000100,
		S_LOAD = 9'b000001000,
		S_BLK  = 9'b000010000,
		S_FMUL = 9'b000100000,
		S_FCMP = 9'b001000000,
		S_ERD  = 9'b010000000,
		S_ELD  = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [KLEN_W-1:0] klen_q, bs_q, k_eff, bs_next;
	logic [HCNT_W-1:0] hcnt_q, hc_eff;
	logic [WIN_W-1:0]  win_q, kmer_q;
	logic [31:0]       mb_q [NBLK];
	logic [BCNT_W-1:0] cnt_q, r_q, nb, nblk;
	logic [HIDX_W-1:0] hidx_q;
	logic [31:0]       h_q, f1_q, f2_q;
	logic [MAX_HASHES-1:0] sig_vld_q;
	logic              sig_vld_rd_q;
	logic              word_vld_q;
	out_item_t         word_q;

	mix_req_t          mreq, mrsp;
	logic [31:0]       seed_rd, sig_rd, sig_cur, rnd, tl, fin_v, fx;
	logic [8:0]        sh;
	logic              accept, last_h, load_out, sig_we, mem_re;

	assign k_eff  = (klen_q > KLEN_W'(MAX_KMER)) ? KLEN_W'(MAX_KMER) : klen_q;
	assign hc_eff = (hcnt_q > HCNT_W'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES) : hcnt_q;
	assign nb     = BCNT_W'(k_eff >> 2);
	assign nblk   = BCNT_W'((7'(k_eff) + 7'd3) >> 2);
	assign sh     = 9'(6'(KLEN_W'(MAX_KMER) - k_eff)) << 3;
	assign bs_next = (bs_q < k_eff) ? bs_q + 1'b1 : bs_q;
	assign last_h = ({1'b0, hidx_q} == hc_eff - 1'b1);

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign mem_re     = (state_q == S_SRD) || (state_q == S_ERD);
	assign sig_cur    = sig_vld_rd_q ? sig_rd : '1;
	assign load_out   = (state_q == S_ELD) && (!word_vld_q || word_ready);

	assign mreq.vld  = (state_q == S_MIX) && (cnt_q < nblk);
	assign mreq.idx  = cnt_q[BLK_W-1:0];
	assign mreq.word = kmer_q[{cnt_q[BLK_W-1:0], 5'b0} +: 32];

	assign rnd   = (rotl32(h_q ^ mb_q[r_q[BLK_W-1:0]], 13) << 2)
		+ rotl32(h_q ^ mb_q[r_q[BLK_W-1:0]], 13) + RND_C;
	assign tl    = ((k_eff[1:0] != 2'd0) ? (h_q ^ mb_q[r_q[BLK_W-1:0]]) : h_q)
		^ 32'(k_eff);
	assign fx    = f1_q ^ (f1_q >> 13);
	assign fin_v = f2_q ^ (f2_q >> 16);
	assign sig_we = (state_q == S_FCMP) && (fin_v < sig_cur);

	kms_block_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	kms_ram #(.DEPTH(MAX_HASHES), .WIDTH(32)) u_seed_ram (
		.clk   (clk),
		.we    (accept && item.kind == KIND_SEED),
		.waddr (item.seed_index[HIDX_W-1:0]),
		.wdata (item.seed_value),
		.re    (state_q == S_SRD),
		.raddr (hidx_q),
		.rdata (seed_rd)
	);

	kms_ram #(.DEPTH(MAX_HASHES), .WIDTH(32)) u_sig_ram (
		.clk   (clk),
		.we    (sig_we),
		.waddr (hidx_q),
		.wdata (fin_v),
		.re    (mem_re),
		.raddr (hidx_q),
		.rdata (sig_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			klen_q       <= KLEN_W'(4);
			hcnt_q       <= HCNT_W'(50);
			bs_q         <= '0;
			win_q        <= '0;
			cnt_q        <= '0;
			r_q          <= '0;
			hidx_q       <= '0;
			sig_vld_q    <= '0;
			sig_vld_rd_q <= 1'b0;
			word_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_KMER_LEN) begin
					klen_q <= cfg_data[KLEN_W-1:0];
				end else begin
					hcnt_q <= cfg_data[HCNT_W-1:0];
				end
			end
			if (mem_re) begin
				sig_vld_rd_q <= sig_vld_q[hidx_q];
			end
			if (sig_we) begin
				sig_vld_q[hidx_q] <= 1'b1;
			end
			if (load_out) begin
				word_vld_q <= 1'b1;
			end else if (word_ready) begin
				word_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					hidx_q <= '0;
					cnt_q  <= '0;
					if (accept && item.kind == KIND_BYTE) begin
						win_q <= {item.symbol, win_q[WIN_W-1:8]};
						bs_q  <= bs_next;
						if (k_eff != '0 && bs_next >= k_eff && hc_eff != '0) begin
							state_q <= S_MIX;
						end
					end else if (accept && item.kind == KIND_END) begin
						if (hc_eff != '0) begin
							state_q <= S_ERD;
						end else begin
							sig_vld_q <= '0;
							win_q     <= '0;
							bs_q      <= '0;
						end
					end
				end
				S_MIX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == nblk + 1'b1) begin
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					r_q     <= '0;
					state_q <= S_BLK;
				end
				S_BLK: begin
					if (r_q < nb) begin
						r_q <= r_q + 1'b1;
					end else begin
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					state_q <= S_FCMP;
				end
				S_FCMP: begin
					if (last_h) begin
						state_q <= S_IDLE;
					end else begin
						hidx_q  <= hidx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					if (load_out) begin
						if (last_h) begin
							sig_vld_q <= '0;
							win_q     <= '0;
							bs_q      <= '0;
							state_q   <= S_IDLE;
						end else begin
							hidx_q  <= hidx_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && item.kind == KIND_BYTE) begin
			kmer_q <= {item.symbol, win_q[WIN_W-1:8]} >> sh;
		end
		if (mrsp.vld) begin
			mb_q[mrsp.idx] <= mrsp.word;
		end
		if (state_q == S_LOAD) begin
			h_q <= seed_rd;
		end else if (state_q == S_BLK && r_q < nb) begin
			h_q <= rnd;
		end
		if (state_q == S_BLK) begin
			f1_q <= (tl ^ (tl >> 16)) * FIN_C1;
		end
		f2_q <= fx * FIN_C2;
		if (load_out) begin
			word_q.hash_index <= hidx_q;
			word_q.min_hash   <= sig_cur;
			word_q.last_word  <= last_h;
		end
	end

	assign word_valid = word_vld_q;
	assign word       = word_q;

endmodule

// ===== sv/kms_checker.sv =====
`include "kmer_minhash_signature_defines.svh"

module kms_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input kms_pkg::in_item_t  item,
	input logic               word_valid,
	input logic               word_ready,
	input kms_pkg::out_item_t word
);
	import kms_pkg::*;

	`KMS_ASSERT_NXT(a_word_hold, word_valid && !word_ready, word_valid)
	`KMS_ASSERT_NXT(a_word_stable, word_valid && !word_ready, $stable(word))
	`KMS_ASSERT_NXT(a_seed_one_cycle, item_valid && item_ready && item.kind == KIND_SEED, item_ready)

endmodule

bind kmer_minhash_signature kms_checker u_kms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.item       (item),
	.word_valid (word_valid),
	.word_ready (word_ready),
	.word       (word)
);
